// ----- hdl/rei_pkg.sv -----
// Shared types, constants and digit-step functions of the ray/ellipsoid intersect pipeline.
package rei_pkg;

    localparam int SQ_STEPS    = 63;
    localparam int SQ_X_W      = 2 * SQ_STEPS;
    localparam int SQ_REM_W    = 66;
    localparam int DIV_T_STEPS = 33;
    localparam int NORM_BITS   = 14;
    localparam int DIV_N_STEPS = NORM_BITS + 1;

    typedef enum logic [2:0] {
        REG_INV_SCALE_X  = 3'd0,
        REG_INV_SCALE_Y  = 3'd1,
        REG_INV_SCALE_Z  = 3'd2,
        REG_INV_OFFSET_X = 3'd3,
        REG_INV_OFFSET_Y = 3'd4,
        REG_INV_OFFSET_Z = 3'd5,
        REG_FAR_LIMIT    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [SQ_X_W-1:0]   x;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_STEPS-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [63:0]            rem;
        logic [DIV_T_STEPS-1:0] quo;
        logic [DIV_T_STEPS-1:0] nb;
        logic [63:0]            den;
        logic                   sat;
        logic                   neg;
    } dvt_t;

    typedef struct packed {
        logic [63:0]            rem;
        logic [DIV_N_STEPS-1:0] quo;
        logic [DIV_N_STEPS-1:0] nb;
        logic [63:0]            den;
    } dvn_t;

    // One root bit: bring down two radicand bits, try subtracting 4*root+1.
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t                 r;
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] sub;
        cur  = {s.rem, s.x[SQ_X_W-1 -: 2]};
        sub  = (SQ_REM_W+2)'({s.root, 2'b01});
        r.x  = s.x << 2;
        if (cur >= sub) begin
            r.rem  = SQ_REM_W'(cur - sub);
            r.root = {s.root[SQ_STEPS-2:0], 1'b1};
        end else begin
            r.rem  = SQ_REM_W'(cur);
            r.root = {s.root[SQ_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    // Restoring division step; returns {quotient bit, new remainder}.
    function automatic logic [64:0] div_step(input logic [63:0] rem, input logic nb,
                                             input logic [63:0] den);
        logic [63:0] cur;
        cur = {rem[62:0], nb};
        if (cur >= den) begin
            return {1'b1, cur - den};
        end else begin
            return {1'b0, cur};
        end
    endfunction

    function automatic dvt_t dvt_step(input dvt_t s);
        logic [64:0] r;
        dvt_t        o;
        r     = div_step(s.rem, s.nb[DIV_T_STEPS-1], s.den);
        o     = s;
        o.rem = r[63:0];
        o.quo = {s.quo[DIV_T_STEPS-2:0], r[64]};
        o.nb  = s.nb << 1;
        return o;
    endfunction

    function automatic dvn_t dvn_step(input dvn_t s);
        logic [64:0] r;
        dvn_t        o;
        r     = div_step(s.rem, s.nb[DIV_N_STEPS-1], s.den);
        o     = s;
        o.rem = r[63:0];
        o.quo = {s.quo[DIV_N_STEPS-2:0], r[64]};
        o.nb  = s.nb << 1;
        return o;
    endfunction

    // Sign-magnitude of a 33-bit saturated quotient as a signed ray parameter.
    function automatic logic signed [33:0] t_val(input dvt_t s);
        logic [32:0] m;
        m = (s.sat || s.quo[DIV_T_STEPS-1]) ? {1'b1, 32'h0} : s.quo;
        return s.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

// ----- hdl/ray_ellipsoid_intersect_top.sv -----
// Ray/axis-aligned-ellipsoid intersection pipeline: hit, distance and unit normal per ray.
//
// Usage:
//   Configure the inverse transform (inv_scale, inv_offset) and far_limit over the
//   APB port while no ray is in flight; pready is tied high, reads return the registers.
//   Present one ray request per cycle on s_* (valid/ready). Each request yields exactly
//   one result request on m_* with hit, distance (Q19.12) and normal (Q1.14); a miss
//   returns hit = 0 and zeros elsewhere.
//   Throughput: one ray per cycle while the receiver does not stall. The pipeline holds two
//   63-stage square-root chains (discriminant and normal length, one root bit per stage),
//   a 33-stage divider pair for the two roots and a 15-stage divider triple for the
//   normal components.
//   The whole pipeline advances as one; when the receiver stalls with a result waiting
//   on m_*, every stage holds and s_ready drops. Bubbles ride along, nothing is lost.
//   Reset (aresetn low, synchronous) drops every in-flight request and restores the
//   registers to identity scale, zero offset and a far limit of 100000.
module ray_ellipsoid_intersect_top #(
    parameter int FRAC_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    input  logic signed [31:0] s_near_limit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [30:0]        m_distance,
    output logic signed [15:0] m_normal_x,
    output logic signed [15:0] m_normal_y,
    output logic signed [15:0] m_normal_z
);
    import rei_pkg::*;

    localparam logic [63:0] ONE_Q    = 64'(1) << FRAC_BITS;
    localparam logic [63:0] ONE_SQ   = 64'(1) << (2 * FRAC_BITS);
    localparam logic [63:0] FAR_FULL = 64'(100000) << FRAC_BITS;
    // Saturate the far reset above every reachable distance (|t| <= 2^32).
    localparam logic [33:0] FAR_RST  = (FAR_FULL > 64'h2_0000_0000) ? 34'h2_0000_0000
                                                                     : 34'(FAR_FULL);
    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int LAT   = 6 + 1 + SQ_STEPS + 2 + DIV_T_STEPS + 2 + 6 + 1 + SQ_STEPS
                           + 1 + DIV_N_STEPS + 1;

    typedef struct packed {
        logic [63:0]       a;
        logic              bneg;
        logic [63:0]       bmag;
        logic              cneg;
        logic [63:0]       cmag;
        logic              tangent;
        logic              miss;
        logic [2:0][30:0]  o;
        logic [2:0][30:0]  d;
        logic [31:0]       near;
    } sb1_t;

    typedef struct packed {
        logic              tangent;
        logic              miss;
        logic [2:0][30:0]  o;
        logic [2:0][30:0]  d;
        logic [31:0]       near;
    } sb2_t;

    typedef struct packed {
        logic              hit;
        logic [30:0]       t_dist;
        logic [2:0]        nneg;
        logic [2:0][63:0]  nmag;
    } sb3_t;

    typedef struct packed {
        logic              hit;
        logic [30:0]       t_dist;
        logic              zero;
        logic [2:0]        nneg;
    } sb4_t;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic signed [31:0] sc_reg  [0:2];
    logic signed [31:0] off_reg [0:2];
    logic [33:0]        far_reg;
    reg_idx_t           cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                sc_reg[i]  <= 32'(ONE_Q);
                off_reg[i] <= '0;
            end
            far_reg <= FAR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_INV_SCALE_X:  sc_reg[0]  <= pwdata;
                REG_INV_SCALE_Y:  sc_reg[1]  <= pwdata;
                REG_INV_SCALE_Z:  sc_reg[2]  <= pwdata;
                REG_INV_OFFSET_X: off_reg[0] <= pwdata;
                REG_INV_OFFSET_Y: off_reg[1] <= pwdata;
                REG_INV_OFFSET_Z: off_reg[2] <= pwdata;
                REG_FAR_LIMIT:    far_reg    <= {3'b000, pwdata[30:0]};
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_INV_SCALE_X:  prdata = sc_reg[0];
            REG_INV_SCALE_Y:  prdata = sc_reg[1];
            REG_INV_SCALE_Z:  prdata = sc_reg[2];
            REG_INV_OFFSET_X: prdata = off_reg[0];
            REG_INV_OFFSET_Y: prdata = off_reg[1];
            REG_INV_OFFSET_Z: prdata = off_reg[2];
            REG_FAR_LIMIT:    prdata = {1'b0, far_reg[30:0]};
            default:          prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, whole pipe advances together
    //------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Map a scaled component into the sphere frame: floor shift, offset, clamp.
    function automatic logic signed [30:0] map_fn(input logic signed [63:0] p,
                                                  input logic signed [31:0] off);
        logic signed [64:0] v;
        v = 65'(p >>> FRAC_BITS) + 65'(off);
        if (v < -65'sd1073741824) begin
            return 31'h4000_0000;
        end else if (v > 65'sd1073741823) begin
            return 31'h3FFF_FFFF;
        end else begin
            return 31'(v);
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v < -66'sd2147483648) begin
            return 32'h8000_0000;
        end else if (v > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else begin
            return 32'(v);
        end
    endfunction

    // Set up a root division: numerator m * 2^F, quotient capped at 2^32.
    function automatic dvt_t init_t(input logic [63:0] m, input logic [63:0] den,
                                    input logic neg);
        logic [NUM_W-1:0] nf;
        logic [63:0]      hi;
        dvt_t             r;
        nf    = NUM_W'(m) << FRAC_BITS;
        hi    = 64'(nf[NUM_W-1:DIV_T_STEPS]);
        r.sat = hi >= den;
        r.rem = r.sat ? '0 : hi;
        r.quo = '0;
        r.nb  = nf[DIV_T_STEPS-1:0];
        r.den = den;
        r.neg = neg;
        return r;
    endfunction

    logic signed [31:0] in_o [0:2];
    logic signed [31:0] in_d [0:2];
    assign in_o[0] = s_origin_x;
    assign in_o[1] = s_origin_y;
    assign in_o[2] = s_origin_z;
    assign in_d[0] = s_dir_x;
    assign in_d[1] = s_dir_y;
    assign in_d[2] = s_dir_z;

    //------------------------------------------------------------------
    // F1..F3: scale, map, component products
    //------------------------------------------------------------------
    logic signed [63:0] f1_po_reg [0:2];
    logic signed [63:0] f1_pd_reg [0:2];
    logic signed [31:0] f1_near_reg;
    logic signed [30:0] f2_o_reg [0:2];
    logic signed [30:0] f2_d_reg [0:2];
    logic signed [31:0] f2_near_reg;
    logic signed [61:0] f3_dd_reg [0:2];
    logic signed [61:0] f3_od_reg [0:2];
    logic signed [61:0] f3_oo_reg [0:2];
    logic signed [30:0] f3_o_reg [0:2];
    logic signed [30:0] f3_d_reg [0:2];
    logic signed [31:0] f3_near_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                f1_po_reg[i] <= sc_reg[i] * in_o[i];
                f1_pd_reg[i] <= sc_reg[i] * in_d[i];
                f2_o_reg[i]  <= map_fn(f1_po_reg[i], off_reg[i]);
                f2_d_reg[i]  <= map_fn(f1_pd_reg[i], 32'sd0);
                f3_dd_reg[i] <= f2_d_reg[i] * f2_d_reg[i];
                f3_od_reg[i] <= f2_o_reg[i] * f2_d_reg[i];
                f3_oo_reg[i] <= f2_o_reg[i] * f2_o_reg[i];
                f3_o_reg[i]  <= f2_o_reg[i];
                f3_d_reg[i]  <= f2_d_reg[i];
            end
            f1_near_reg <= s_near_limit;
            f2_near_reg <= f1_near_reg;
            f3_near_reg <= f2_near_reg;
        end
    end

    //------------------------------------------------------------------
    // F4: quadratic coefficients A, B, C
    //------------------------------------------------------------------
    logic signed [63:0] a_sum, b_sum, o_sum, c_sum;
    sb1_t               f4_next;
    sb1_t               f4_reg, f5_reg, f6_reg;

    always_comb begin
        a_sum = 64'(f3_dd_reg[0]) + 64'(f3_dd_reg[1]) + 64'(f3_dd_reg[2]);
        b_sum = 64'(f3_od_reg[0]) + 64'(f3_od_reg[1]) + 64'(f3_od_reg[2]);
        o_sum = 64'(f3_oo_reg[0]) + 64'(f3_oo_reg[1]) + 64'(f3_oo_reg[2]);
        c_sum = o_sum - $signed(ONE_SQ);
        f4_next.a       = a_sum;
        f4_next.bneg    = b_sum[63];
        f4_next.bmag    = b_sum[63] ? 64'(-b_sum) : 64'(b_sum);
        f4_next.cneg    = c_sum[63];
        f4_next.cmag    = c_sum[63] ? 64'(-c_sum) : 64'(c_sum);
        f4_next.tangent = 1'b0;
        f4_next.miss    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            f4_next.o[i] = f3_o_reg[i];
            f4_next.d[i] = f3_d_reg[i];
        end
        f4_next.near = f3_near_reg;
    end

    //------------------------------------------------------------------
    // F5/F6: B^2 and A*|C| from 32x32 partial products
    //------------------------------------------------------------------
    logic [63:0]  f5_bll_reg, f5_blh_reg, f5_bhh_reg;
    logic [63:0]  f5_all_reg, f5_alh_reg, f5_ahl_reg, f5_ahh_reg;
    logic [127:0] f6_b2_reg, f6_ac_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f4_reg     <= f4_next;
            f5_reg     <= f4_reg;
            f5_bll_reg <= f4_reg.bmag[31:0] * f4_reg.bmag[31:0];
            f5_blh_reg <= f4_reg.bmag[31:0] * f4_reg.bmag[63:32];
            f5_bhh_reg <= f4_reg.bmag[63:32] * f4_reg.bmag[63:32];
            f5_all_reg <= f4_reg.a[31:0] * f4_reg.cmag[31:0];
            f5_alh_reg <= f4_reg.a[31:0] * f4_reg.cmag[63:32];
            f5_ahl_reg <= f4_reg.a[63:32] * f4_reg.cmag[31:0];
            f5_ahh_reg <= f4_reg.a[63:32] * f4_reg.cmag[63:32];
            f6_reg     <= f5_reg;
            f6_b2_reg  <= (128'(f5_bhh_reg) << 64) + (128'(f5_blh_reg) << 33)
                          + 128'(f5_bll_reg);
            f6_ac_reg  <= (128'(f5_ahh_reg) << 64) + (128'(f5_alh_reg) << 32)
                          + (128'(f5_ahl_reg) << 32) + 128'(f5_all_reg);
        end
    end

    //------------------------------------------------------------------
    // F7: discriminant, then one root bit per stage
    //------------------------------------------------------------------
    logic [127:0] disc;
    logic         disc_neg;
    sq_t          sq1_in;
    sb1_t         sb1_in;
    sq_t          sq1_reg [0:SQ_STEPS];
    sb1_t         sb1_reg [0:SQ_STEPS];

    always_comb begin
        if (f6_reg.cneg) begin
            disc     = f6_b2_reg + f6_ac_reg;
            disc_neg = 1'b0;
        end else begin
            disc     = f6_b2_reg - f6_ac_reg;
            disc_neg = f6_b2_reg < f6_ac_reg;
        end
        sq1_in.x       = disc[SQ_X_W-1:0];
        sq1_in.rem     = '0;
        sq1_in.root    = '0;
        sb1_in         = f6_reg;
        sb1_in.tangent = disc == '0;
        sb1_in.miss    = (f6_reg.a == '0) || disc_neg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq1_reg[0] <= sq1_in;
            sb1_reg[0] <= sb1_in;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sq1_reg[k] <= sqrt_step(sq1_reg[k-1]);
                sb1_reg[k] <= sb1_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // Q: stable q = -B - sgn(B) sqrt(D); |q| = |B| + s
    //------------------------------------------------------------------
    logic [63:0] q_qmag_reg;
    logic        q_qneg_reg;
    sb1_t        q_sb_reg;
    dvt_t        dv0_reg [0:DIV_T_STEPS];
    dvt_t        dv1_reg [0:DIV_T_STEPS];
    sb2_t        sb2_reg [0:DIV_T_STEPS];
    dvt_t        dv0_in, dv1_in;
    sb2_t        sb2_in;

    always_comb begin
        if (q_sb_reg.tangent) begin
            dv0_in = init_t(q_sb_reg.bmag, q_sb_reg.a, !q_sb_reg.bneg);
        end else begin
            dv0_in = init_t(q_qmag_reg, q_sb_reg.a, q_qneg_reg);
        end
        dv1_in = init_t(q_sb_reg.cmag, (q_qmag_reg == '0) ? 64'd1 : q_qmag_reg,
                        q_sb_reg.cneg ^ q_qneg_reg);
        sb2_in.tangent = q_sb_reg.tangent;
        sb2_in.miss    = q_sb_reg.miss;
        sb2_in.o       = q_sb_reg.o;
        sb2_in.d       = q_sb_reg.d;
        sb2_in.near    = q_sb_reg.near;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_qmag_reg <= sb1_reg[SQ_STEPS].bmag + 64'(sq1_reg[SQ_STEPS].root);
            q_qneg_reg <= !sb1_reg[SQ_STEPS].bneg;
            q_sb_reg   <= sb1_reg[SQ_STEPS];
            dv0_reg[0] <= dv0_in;
            dv1_reg[0] <= dv1_in;
            sb2_reg[0] <= sb2_in;
            for (int k = 1; k <= DIV_T_STEPS; k++) begin
                dv0_reg[k] <= dvt_step(dv0_reg[k-1]);
                dv1_reg[k] <= dvt_step(dv1_reg[k-1]);
                sb2_reg[k] <= sb2_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // T1/T2: signed roots, root choice, near/far acceptance
    //------------------------------------------------------------------
    logic signed [33:0] t1_a_reg, t1_b_reg;
    sb2_t               t1_sb_reg;
    logic signed [33:0] t_lo, t_hi, t_sel, near34;
    logic signed [34:0] far35;
    logic               accept;
    logic signed [33:0] t2_t_reg;
    logic               t2_hit_reg;
    logic [30:0]        t2_dist_reg;
    logic [2:0][30:0]   t2_o_reg, t2_d_reg;

    always_comb begin
        near34 = 34'($signed(t1_sb_reg.near));
        far35  = $signed({1'b0, far_reg});
        t_lo   = (t1_a_reg < t1_b_reg) ? t1_a_reg : t1_b_reg;
        t_hi   = (t1_a_reg < t1_b_reg) ? t1_b_reg : t1_a_reg;
        if (t1_sb_reg.tangent) begin
            t_sel = t1_a_reg;
        end else begin
            t_sel = (t_lo < near34) ? t_hi : t_lo;
        end
        accept = !t1_sb_reg.miss && (t_sel > near34) && (35'(t_sel) < far35);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_a_reg    <= t_val(dv0_reg[DIV_T_STEPS]);
            t1_b_reg    <= t_val(dv1_reg[DIV_T_STEPS]);
            t1_sb_reg   <= sb2_reg[DIV_T_STEPS];
            t2_t_reg    <= t_sel;
            t2_hit_reg  <= accept;
            t2_dist_reg <= (!accept || t_sel[33]) ? '0 : t_sel[30:0];
            t2_o_reg    <= t1_sb_reg.o;
            t2_d_reg    <= t1_sb_reg.d;
        end
    end

    //------------------------------------------------------------------
    // N1..N6: hit point, inverse-transpose scaling, squared length terms
    //------------------------------------------------------------------
    logic signed [64:0] n1_pt_reg [0:2];
    logic [2:0][30:0]   n1_o_reg;
    logic signed [31:0] n2_p_reg [0:2];
    logic signed [63:0] n3_n_reg [0:2];
    logic [63:0]        n4_mag_reg [0:2];
    logic [2:0]         n4_neg_reg;
    logic [63:0]        n5_ll_reg [0:2];
    logic [63:0]        n5_lh_reg [0:2];
    logic [63:0]        n5_hh_reg [0:2];
    logic [127:0]       n6_sq_reg [0:2];
    logic               n_hit_reg  [1:6];
    logic [30:0]        n_dist_reg [1:6];
    logic [63:0]        n5_mag_reg [0:2];
    logic [2:0]         n5_neg_reg;
    logic [63:0]        n6_mag_reg [0:2];
    logic [2:0]         n6_neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n1_pt_reg[i]  <= t2_t_reg * $signed(t2_d_reg[i]);
                n2_p_reg[i]   <= clamp32(66'($signed(n1_o_reg[i]))
                                         + 66'(n1_pt_reg[i] >>> FRAC_BITS));
                n3_n_reg[i]   <= sc_reg[i] * n2_p_reg[i];
                n4_mag_reg[i] <= n3_n_reg[i][63] ? 64'(-n3_n_reg[i]) : 64'(n3_n_reg[i]);
                n4_neg_reg[i] <= n3_n_reg[i][63];
                n5_ll_reg[i]  <= n4_mag_reg[i][31:0] * n4_mag_reg[i][31:0];
                n5_lh_reg[i]  <= n4_mag_reg[i][31:0] * n4_mag_reg[i][63:32];
                n5_hh_reg[i]  <= n4_mag_reg[i][63:32] * n4_mag_reg[i][63:32];
                n5_mag_reg[i] <= n4_mag_reg[i];
                n6_sq_reg[i]  <= (128'(n5_hh_reg[i]) << 64) + (128'(n5_lh_reg[i]) << 33)
                                 + 128'(n5_ll_reg[i]);
                n6_mag_reg[i] <= n5_mag_reg[i];
            end
            n1_o_reg      <= t2_o_reg;
            n5_neg_reg    <= n4_neg_reg;
            n6_neg_reg    <= n5_neg_reg;
            n_hit_reg[1]  <= t2_hit_reg;
            n_dist_reg[1] <= t2_dist_reg;
            for (int k = 2; k <= 6; k++) begin
                n_hit_reg[k]  <= n_hit_reg[k-1];
                n_dist_reg[k] <= n_dist_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // N7: squared length, then normal length one bit per stage
    //------------------------------------------------------------------
    sq_t          sq2_in;
    sb3_t         sb3_in;
    logic [127:0] s2_sum;
    sq_t          sq2_reg [0:SQ_STEPS];
    sb3_t         sb3_reg [0:SQ_STEPS];

    always_comb begin
        s2_sum        = n6_sq_reg[0] + n6_sq_reg[1] + n6_sq_reg[2];
        sq2_in.x      = s2_sum[SQ_X_W-1:0];
        sq2_in.rem    = '0;
        sq2_in.root   = '0;
        sb3_in.hit    = n_hit_reg[6];
        sb3_in.t_dist = n_dist_reg[6];
        sb3_in.nneg   = n6_neg_reg;
        for (int i = 0; i < 3; i++) begin
            sb3_in.nmag[i] = n6_mag_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq2_reg[0] <= sq2_in;
            sb3_reg[0] <= sb3_in;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                sq2_reg[k] <= sqrt_step(sq2_reg[k-1]);
                sb3_reg[k] <= sb3_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // N8: normalize each component, |n| * 2^14 / len (quotient <= 2^14)
    //------------------------------------------------------------------
    dvn_t        dn_in [0:2];
    sb4_t        sb4_in;
    logic [63:0] len_v;
    dvn_t        dn_reg [0:2][0:DIV_N_STEPS];
    sb4_t        sb4_reg [0:DIV_N_STEPS];

    always_comb begin
        len_v         = 64'(sq2_reg[SQ_STEPS].root);
        sb4_in.hit    = sb3_reg[SQ_STEPS].hit;
        sb4_in.t_dist = sb3_reg[SQ_STEPS].t_dist;
        sb4_in.zero   = len_v == '0;
        sb4_in.nneg   = sb3_reg[SQ_STEPS].nneg;
        for (int i = 0; i < 3; i++) begin
            dn_in[i].rem = sb3_reg[SQ_STEPS].nmag[i] >> 1;
            dn_in[i].quo = '0;
            dn_in[i].nb  = {sb3_reg[SQ_STEPS].nmag[i][0], {NORM_BITS{1'b0}}};
            dn_in[i].den = (len_v == '0) ? 64'd1 : len_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb4_reg[0] <= sb4_in;
            for (int i = 0; i < 3; i++) begin
                dn_reg[i][0] <= dn_in[i];
                for (int k = 1; k <= DIV_N_STEPS; k++) begin
                    dn_reg[i][k] <= dvn_step(dn_reg[i][k-1]);
                end
            end
            for (int k = 1; k <= DIV_N_STEPS; k++) begin
                sb4_reg[k] <= sb4_reg[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // Output register: zero everything but hit on a miss, zero normal on zero length
    //------------------------------------------------------------------
    logic signed [15:0] nrm [0:2];
    sb4_t               sb4_last;
    logic               nrm_on;

    always_comb begin
        sb4_last = sb4_reg[DIV_N_STEPS];
        nrm_on   = sb4_last.hit && !sb4_last.zero;
        for (int i = 0; i < 3; i++) begin
            if (!nrm_on) begin
                nrm[i] = '0;
            end else if (sb4_last.nneg[i]) begin
                nrm[i] = -$signed(16'(dn_reg[i][DIV_N_STEPS].quo));
            end else begin
                nrm[i] = $signed(16'(dn_reg[i][DIV_N_STEPS].quo));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit      <= sb4_last.hit;
            m_distance <= sb4_last.hit ? sb4_last.t_dist : '0;
            m_normal_x <= nrm[0];
            m_normal_y <= nrm[1];
            m_normal_z <= nrm[2];
        end
    end

endmodule
